// ===== hw/rtl/une_pkg.sv =====
package une_pkg;

	typedef enum logic [1:0] {
		MODE_PATH   = 2'd0,
		MODE_MANGLE = 2'd1,
		MODE_GLOB   = 2'd2
	} escape_mode_t;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_DASH      = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_AT        = 8'h40;

	localparam logic [1:0] IDX_FIRST    = 2'd0;
	localparam logic [1:0] IDX_X        = 2'd1;
	localparam logic [1:0] IDX_HI       = 2'd2;
	localparam logic [1:0] IDX_LO       = 2'd3;

	typedef struct packed {
		logic [7:0] char_in;
		logic       name_end;
	} une_in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       run_last;
		logic       name_end_out;
	} une_out_t;

	// Decoded word between the classifier and the serializer.
	typedef struct packed {
		logic [7:0] ch;
		logic       escape;
		logic       name_end;
	} une_word_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'b0000, nib};
		if (nib < 4'd10) begin
			return 8'h30 + ext;
		end
		return 8'h57 + ext;
	endfunction

	function automatic logic byte_allowed(input logic [7:0] ch, input logic [1:0] mode);
		logic ok;
		ok = ch inside {["0":"9"], ["a":"z"], ["A":"Z"], 8'h3A, 8'h5F, CH_DOT};
		if (!ok && mode != MODE_PATH) begin
			ok = ch inside {CH_DASH, CH_BACKSLASH, CH_AT};
			// Unused mode code behaves as the glob mode.
			if (!ok && mode != MODE_MANGLE) begin
				ok = ch inside {8'h5B, 8'h5D, 8'h21, 8'h2A, 8'h3F};
			end
		end
		return ok;
	endfunction

endpackage

// ===== hw/rtl/une_classify.sv =====
module une_classify
	import une_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       item_valid,
	output logic       item_ready,
	input  une_in_t    item,
	output logic       word_valid,
	input  logic       word_ready,
	output une_word_t  word
);

	logic [1:0] mode_q;
	logic       at_name_start_q;
	logic       valid_s1;
	une_in_t    item_s1;
	logic       start_s1;
	logic       esc;

	assign item_ready = !valid_s1 || word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_PATH;
			at_name_start_q <= 1'b1;
			valid_s1        <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (item_valid && item_ready) begin
				at_name_start_q <= item.name_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1  <= item;
			start_s1 <= at_name_start_q;
		end
	end

	always_comb begin
		esc = !byte_allowed(item_s1.char_in, mode_q);
		// In path mode a dot that opens a name is hidden by escaping it.
		if (mode_q == MODE_PATH && item_s1.char_in == CH_DOT && start_s1) begin
			esc = 1'b1;
		end
		word.name_end = item_s1.name_end;
		if (item_s1.char_in == CH_SLASH) begin
			word.ch     = CH_DASH;
			word.escape = 1'b0;
		end else begin
			word.ch     = item_s1.char_in;
			word.escape = esc;
		end
	end

	assign word_valid = valid_s1;

	a_slash_plain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.char_in == CH_SLASH |-> !word.escape && word.ch == CH_DASH)
		else $error("slash must map to a single dash");

	a_start_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(item_valid && item_ready) |-> at_name_start_q == item_s1.name_end)
		else $error("name start flag out of step with last word");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !word_ready |=> valid_s1 && $stable(item_s1))
		else $error("stalled stage lost its word");

endmodule

// ===== hw/rtl/une_serializer.sv =====
module une_serializer
	import une_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      word_valid,
	output logic      word_ready,
	input  une_word_t word,
	output logic      result_valid,
	input  logic      result_ready,
	output une_out_t  result
);

	logic       pend_valid_q;
	une_word_t  pend_q;
	logic [1:0] idx_q;
	logic       result_valid_q;
	une_out_t   result_q;
	logic       out_load;
	logic       is_last;
	logic       pend_done;
	logic [7:0] cur_byte;

	assign out_load   = pend_valid_q && (!result_valid_q || result_ready);
	assign is_last    = pend_q.escape ? (idx_q == IDX_LO) : 1'b1;
	assign pend_done  = out_load && is_last;
	assign word_ready = !pend_valid_q || pend_done;

	always_comb begin
		case (idx_q)
			IDX_FIRST: cur_byte = pend_q.escape ? CH_BACKSLASH : pend_q.ch;
			IDX_X:     cur_byte = CH_X;
			IDX_HI:    cur_byte = hex_digit(pend_q.ch[7:4]);
			IDX_LO:    cur_byte = hex_digit(pend_q.ch[3:0]);
			default:   cur_byte = pend_q.ch;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q   <= 1'b0;
			idx_q          <= IDX_FIRST;
			result_valid_q <= 1'b0;
		end else begin
			if (word_ready) begin
				pend_valid_q <= word_valid;
			end
			if (pend_done || (word_valid && word_ready)) begin
				idx_q <= IDX_FIRST;
			end else if (out_load) begin
				idx_q <= idx_q + 2'd1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && word_ready) begin
			pend_q <= word;
		end
		if (out_load) begin
			result_q.char_out     <= cur_byte;
			result_q.run_last     <= is_last;
			result_q.name_end_out <= is_last && pend_q.name_end;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_idx_only_escaped: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q && idx_q != IDX_FIRST |-> pend_q.escape)
		else $error("byte index advanced on a plain word");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_valid_q |-> idx_q == IDX_FIRST)
		else $error("byte index left behind with no word pending");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.name_end_out |-> result_q.run_last)
		else $error("name end flagged before the last byte of a run");

endmodule

// ===== hw/rtl/unit_name_escape_encoder_core.sv =====
// Name escape encoder.
// Input channel item_valid/item_ready carries one raw byte of a name per word,
// with name_end set on the final byte of each name. Output channel
// result_valid/result_ready carries the escaped bytes one word at a time;
// run_last marks the final output byte for an input byte and name_end_out
// marks the final output byte of a whole name.
// The mode register, written via cfg_we/cfg_wdata, selects path escaping,
// mangling, or mangling that keeps globs; the user must write it only while
// the block is idle, which the block does not enforce. A word is registered
// in the classifier stage, the pending word and the output register. A plain
// byte gives one output byte and an escaped byte four; throughput is one
// output byte per cycle while result_ready is high, set by the single output
// register that the serializer drives. Input is accepted every cycle while
// the serializer keeps pace; a word waiting in the output register does not
// block the input stage. Reset clears the mode to path escaping and arms the
// name-start flag. When the receiver stalls, the output holds its word and
// the two internal stages fill, after which item_ready drops.
module unit_name_escape_encoder_core
	import une_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       item_valid,
	output logic       item_ready,
	input  une_in_t    item,
	output logic       result_valid,
	input  logic       result_ready,
	output une_out_t   result
);

	logic      word_valid;
	logic      word_ready;
	une_word_t word;

	une_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word)
	);

	une_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word         (word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== tb/tb_unit_name_escape_encoder_core.sv =====
module tb_unit_name_escape_encoder_core;
	import une_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 56;
	localparam int HOLD_CYCLES = 120;

	// Predicts the escaped byte stream and checks the output against it.
	class escape_scoreboard;
		logic [1:0] mode;
		bit at_start;
		une_out_t escaped_q[$];
		int errors;

		function new();
			mode = MODE_PATH;
			at_start = 1'b1;
			errors = 0;
		endfunction

		function bit allowed(logic [7:0] c);
			if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
			    || c == ":" || c == "_" || c == CH_DOT) begin
				return 1'b1;
			end
			if (mode == MODE_PATH) begin
				return 1'b0;
			end
			if (c == CH_DASH || c == CH_BACKSLASH || c == CH_AT) begin
				return 1'b1;
			end
			if (mode == MODE_MANGLE) begin
				return 1'b0;
			end
			return c == "[" || c == "]" || c == "!" || c == "*" || c == "?";
		endfunction

		function logic [7:0] hex_char(logic [3:0] n);
			return (n < 4'd10) ? 8'h30 + n : 8'h61 + n - 8'd10;
		endfunction

		function void push_byte(logic [7:0] c, bit last, bit fin);
			une_out_t o;
			o.char_out = c;
			o.run_last = last;
			o.name_end_out = last && fin;
			escaped_q.push_back(o);
		endfunction

		function void note_word(une_in_t w);
			logic [7:0] c;
			bit esc;
			c = w.char_in;
			if (c == CH_SLASH) begin
				push_byte(CH_DASH, 1'b1, w.name_end);
			end else begin
				esc = !allowed(c);
				// In path mode a dot may not open a name.
				if (mode == MODE_PATH && c == CH_DOT && at_start) begin
					esc = 1'b1;
				end
				if (esc) begin
					push_byte(CH_BACKSLASH, 1'b0, 1'b0);
					push_byte(CH_X, 1'b0, 1'b0);
					push_byte(hex_char(c[7:4]), 1'b0, 1'b0);
					push_byte(hex_char(c[3:0]), 1'b1, w.name_end);
				end else begin
					push_byte(c, 1'b1, w.name_end);
				end
			end
			at_start = w.name_end;
		endfunction

		function void check_byte(une_out_t got);
			une_out_t want;
			if (escaped_q.size() == 0) begin
				$error("output word %h arrived with nothing expected", got);
				errors++;
				return;
			end
			want = escaped_q.pop_front();
			if (got.char_out !== want.char_out) begin
				$error("char_out: expected %h, got %h", want.char_out, got.char_out);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				errors++;
			end
			if (got.name_end_out !== want.name_end_out) begin
				$error("name_end_out: expected %b, got %b", want.name_end_out,
				       got.name_end_out);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;
	logic item_valid;
	logic item_ready;
	une_in_t item;
	logic result_valid;
	logic result_ready;
	une_out_t result;

	escape_scoreboard sb = new();
	bit hold_req = 1'b0;
	int cycles = 0;

	logic [7:0] specials [16] = '{CH_DOT, CH_SLASH, CH_DASH, CH_BACKSLASH, CH_AT, "[", "]",
		"!", "*", "?", ":", "_", "a", "Z", "0", 8'h00};
	logic [1:0] phase_modes [RANDOM_PHASES] = '{MODE_GLOB, MODE_PATH, MODE_UNUSED,
		MODE_MANGLE, MODE_PATH, MODE_GLOB, MODE_MANGLE, MODE_PATH};

	unit_name_escape_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Nothing changes between the falling edge and the next rising edge, so a
	// word seen valid and ready here is the one taken at that rising edge.
	always @(negedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_byte(result);
		end
	end

	initial begin
		int stall;
		int calm;
		int r;
		stall = 0;
		calm = 0;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				calm = 0;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else if (calm > 0) begin
				result_ready <= 1'b1;
				calm--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					calm = $urandom_range(20, 60);
					result_ready <= 1'b1;
				end else if (r < 75) begin
					result_ready <= 1'b1;
				end else if (r < 97) begin
					stall = $urandom_range(0, 2);
					result_ready <= 1'b0;
				end else begin
					stall = $urandom_range(7, 29);
					result_ready <= 1'b0;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	task automatic idle(input int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Valid stays high after acceptance; the next idle or word decides.
	task automatic send_word(input logic [7:0] c, input logic fin);
		une_in_t w;
		w.char_in = c;
		w.name_end = fin;
		item_valid <= 1'b1;
		item <= w;
		do @(negedge clk); while (!item_ready);
		sb.note_word(w);
		@(posedge clk);
	endtask

	task automatic feed(input logic [7:0] c, input logic fin, input bit no_gaps);
		idle(no_gaps ? 0 : pick_gap());
		send_word(c, fin);
	endtask

	task automatic feed_random(input bit no_gaps);
		logic [7:0] c;
		logic fin;
		if (sb.at_start && $urandom_range(0, 2) == 0) begin
			c = CH_DOT;
		end else if ($urandom_range(0, 1) == 1) begin
			c = 8'($urandom_range(0, 255));
		end else begin
			c = specials[4'($urandom_range(0, 15))];
		end
		fin = ($urandom_range(0, 5) == 0);
		feed(c, fin, no_gaps);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.escaped_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_PATH;
		item_valid <= 1'b0;
		item <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Path mode straight out of reset.
		feed(CH_DOT, 1'b0, 1'b0);
		feed(CH_DOT, 1'b0, 1'b0);
		feed(CH_DASH, 1'b0, 1'b0);
		feed(CH_BACKSLASH, 1'b0, 1'b0);
		feed(CH_SLASH, 1'b1, 1'b0);
		feed(CH_SLASH, 1'b0, 1'b0);
		feed(8'h00, 1'b0, 1'b0);
		feed(8'hFF, 1'b1, 1'b0);
		feed(CH_DOT, 1'b1, 1'b0);

		write_mode(MODE_MANGLE);
		feed(CH_DOT, 1'b0, 1'b0);
		feed(CH_AT, 1'b0, 1'b0);
		feed(CH_DASH, 1'b0, 1'b0);
		feed(CH_BACKSLASH, 1'b0, 1'b0);
		feed("*", 1'b0, 1'b0);
		feed("Z", 1'b1, 1'b0);

		write_mode(MODE_GLOB);
		feed("[", 1'b0, 1'b0);
		feed("]", 1'b0, 1'b0);
		feed("!", 1'b0, 1'b0);
		feed("?", 1'b0, 1'b0);
		feed("*", 1'b1, 1'b0);

		// The unused code must act like the glob mode.
		write_mode(MODE_UNUSED);
		feed("?", 1'b0, 1'b0);
		feed(":", 1'b0, 1'b0);
		feed("_", 1'b0, 1'b0);
		feed(8'h80, 1'b1, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_mode(phase_modes[p]);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if (p == 2 && i == 20) begin
					hold_req = 1'b1;
				end
				if (p == 4 && i == 28) begin
					drain();
				end
				feed_random(p == 5);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.escaped_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
